// File: rtl/core/rbmd_pkg.sv
package rbmd_pkg;

   localparam int unsigned MaxOutWidth = 4096;

   localparam int SampleW  = 32;
   localparam int ColW     = 12;
   localparam int RowW     = 16;
   localparam int FactorW  = 9;
   localparam int DimW     = 16;
   localparam int CellCntW = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   localparam logic [FactorW-1:0] FactorMax = FactorW'(256);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BLOCK_FACTOR,
      CSR_IN_WIDTH,
      CSR_IN_HEIGHT,
      CSR_NODATA_ENABLE,
      CSR_NODATA_VALUE
   } csr_index_type;

   localparam logic [FactorW-1:0]        BlockFactorReset  = FactorW'(1);
   localparam logic [DimW-1:0]           InWidthReset      = DimW'(4096);
   localparam logic [DimW-1:0]           InHeightReset     = DimW'(4096);
   localparam logic                      NodataEnableReset = 1'b0;
   localparam logic signed [SampleW-1:0] NodataValueReset  = '0;

   // Fixed no-data sentinels in Q23.8: -32767, -32768, -9999 and -99999.
   localparam logic signed [SampleW-1:0] Sentinel0 = -32'sd8388352;
   localparam logic signed [SampleW-1:0] Sentinel1 = -32'sd8388608;
   localparam logic signed [SampleW-1:0] Sentinel2 = -32'sd2559744;
   localparam logic signed [SampleW-1:0] Sentinel3 = -32'sd25599744;

   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic                      not_finite;
   } req_type;

   typedef struct packed {
      logic signed [SampleW-1:0] cell_value;
      logic                      cell_has_value;
      logic [ColW-1:0]           cell_column;
      logic [RowW-1:0]           cell_row;
      logic                      last_of_row;
      logic                      last_of_image;
   } rsp_type;

   // Position of one transaction within the raster, from the scan counters.
   typedef struct packed {
      logic            first;
      logic            emit;
      logic            in_range;
      logic            last_of_row;
      logic            last_of_image;
      logic [ColW-1:0] column;
      logic [RowW-1:0] row;
   } scan_info_type;

endpackage

// File: rtl/core/raster_block_max_downsample.sv
// Pipeline: an accepted sample is registered in the first stage, which gets its line store
// entry; its cell result is then registered in the output register. One sample per cycle
// unless a full output register stalls the first stage; the store is read at acceptance and
// written back as the sample leaves that stage, with a bypass for a next sample on the same entry.
// Reset clears the scan counters and the pipeline and loads the register defaults.
// The line store is not cleared: the first pixel of each cell overwrites its entry.
module raster_block_max_downsample #(
   parameter int unsigned MAX_OUT_WIDTH = rbmd_pkg::MaxOutWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rbmd_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rbmd_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [rbmd_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [rbmd_pkg::CsrDataW-1:0]   csr_wdata
);
   import rbmd_pkg::*;

   localparam int AddrW = $clog2(MAX_OUT_WIDTH);
   localparam int EntryW = SampleW + 1;

   // Configuration registers.
   logic [FactorW-1:0]        block_factor_ff, block_factor_in;
   logic [DimW-1:0]           in_width_ff, in_width_in;
   logic [DimW-1:0]           in_height_ff, in_height_in;
   logic                      nodata_enable_ff, nodata_enable_in;
   logic signed [SampleW-1:0] nodata_value_ff, nodata_value_in;

   logic [FactorW-1:0] factor_eff;
   logic [DimW-1:0]    width_eff, height_eff;

   logic                      accept, is_nodata, keep;
   logic [AddrW-1:0]          scan_addr;
   scan_info_type             scan_info;

   // Stage after acceptance: line store data is available here.
   logic                      s1_valid_ff, s1_valid_in;
   scan_info_type             s1_info_ff, s1_info_in;
   logic signed [SampleW-1:0] s1_sample_ff, s1_sample_in;
   logic                      s1_keep_ff, s1_keep_in;
   logic [AddrW-1:0]          s1_addr_ff, s1_addr_in;
   logic                      fwd_ff, fwd_in;
   logic [EntryW-1:0]         fwd_data_ff, fwd_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [EntryW-1:0]         ram_rd_data, cur_entry, new_entry;
   logic                      cur_has, new_has;
   logic signed [SampleW-1:0] cur_max, new_max;
   logic                      s1_advance, s1_write;

   always_comb begin
      block_factor_in  = block_factor_ff;
      in_width_in      = in_width_ff;
      in_height_in     = in_height_ff;
      nodata_enable_in = nodata_enable_ff;
      nodata_value_in  = nodata_value_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_FACTOR:  block_factor_in  = csr_wdata[FactorW-1:0];
            CSR_IN_WIDTH:      in_width_in      = csr_wdata[DimW-1:0];
            CSR_IN_HEIGHT:     in_height_in     = csr_wdata[DimW-1:0];
            CSR_NODATA_ENABLE: nodata_enable_in = csr_wdata[0];
            CSR_NODATA_VALUE:  nodata_value_in  = csr_wdata[SampleW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_factor_ff  <= BlockFactorReset;
         in_width_ff      <= InWidthReset;
         in_height_ff     <= InHeightReset;
         nodata_enable_ff <= NodataEnableReset;
         nodata_value_ff  <= NodataValueReset;
      end else begin
         block_factor_ff  <= block_factor_in;
         in_width_ff      <= in_width_in;
         in_height_ff     <= in_height_in;
         nodata_enable_ff <= nodata_enable_in;
         nodata_value_ff  <= nodata_value_in;
      end
   end

   always_comb begin
      if (block_factor_ff == '0) begin
         factor_eff = FactorW'(1);
      end else if (block_factor_ff > FactorMax) begin
         factor_eff = FactorMax;
      end else begin
         factor_eff = block_factor_ff;
      end
      width_eff  = (in_width_ff == '0) ? DimW'(1) : in_width_ff;
      height_eff = (in_height_ff == '0) ? DimW'(1) : in_height_ff;
   end

   always_comb begin
      if (nodata_enable_ff) begin
         is_nodata = req_data.sample == nodata_value_ff;
      end else begin
         is_nodata = (req_data.sample == Sentinel0) || (req_data.sample == Sentinel1) ||
                     (req_data.sample == Sentinel2) || (req_data.sample == Sentinel3);
      end
      keep = !req_data.not_finite && !is_nodata;
   end

   // The first stage may move on unless its result would land on a full output register.
   assign s1_advance = s1_valid_ff &&
                       (!s1_info_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign s1_write   = s1_advance && s1_info_ff.in_range;

   rbmd_scan #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .factor (factor_eff),
      .width  (width_eff),
      .height (height_eff),
      .addr   (scan_addr),
      .info   (scan_info)
   );

   rbmd_ram #(
      .Width(EntryW),
      .Depth(MAX_OUT_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_addr_ff),
      .wr_data (new_entry),
      .rd_en   (accept),
      .rd_addr (scan_addr),
      .rd_data (ram_rd_data)
   );

   // Read-modify-write of the cell's running maximum.
   always_comb begin
      cur_entry = fwd_ff ? fwd_data_ff : ram_rd_data;
      cur_has   = cur_entry[EntryW-1];
      cur_max   = cur_entry[SampleW-1:0];
      if (s1_info_ff.first) begin
         new_has = s1_keep_ff;
         new_max = s1_keep_ff ? s1_sample_ff : '0;
      end else if (s1_keep_ff) begin
         new_has = 1'b1;
         new_max = (!cur_has || (s1_sample_ff > cur_max)) ? s1_sample_ff : cur_max;
      end else begin
         new_has = cur_has;
         new_max = cur_max;
      end
      new_entry = {new_has, new_max};
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_info_in   = s1_info_ff;
      s1_sample_in = s1_sample_ff;
      s1_keep_in   = s1_keep_ff;
      s1_addr_in   = s1_addr_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_info_in   = scan_info;
         s1_sample_in = req_data.sample;
         s1_keep_in   = keep;
         s1_addr_in   = scan_addr;
         // The store is written at the same edge this read is taken, so bypass it.
         fwd_in       = s1_write && (s1_addr_ff == scan_addr);
         fwd_data_in  = new_entry;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance && s1_info_ff.emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.cell_value     = new_has ? new_max : '0;
         rsp_data_in.cell_has_value = new_has;
         rsp_data_in.cell_column    = s1_info_ff.column;
         rsp_data_in.cell_row       = s1_info_ff.row;
         rsp_data_in.last_of_row    = s1_info_ff.last_of_row;
         rsp_data_in.last_of_image  = s1_info_ff.last_of_image;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff   <= s1_info_in;
      s1_sample_ff <= s1_sample_in;
      s1_keep_ff   <= s1_keep_in;
      s1_addr_ff   <= s1_addr_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/rbmd_ram.sv
module rbmd_ram #(
   parameter int Width = 33,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] ram_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rbmd_scan.sv
module rbmd_scan #(
   parameter int unsigned MAX_OUT_WIDTH = rbmd_pkg::MaxOutWidth
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [rbmd_pkg::FactorW-1:0]       factor,
   input  logic [rbmd_pkg::DimW-1:0]          width,
   input  logic [rbmd_pkg::DimW-1:0]          height,
   output logic [$clog2(MAX_OUT_WIDTH)-1:0]   addr,
   output rbmd_pkg::scan_info_type            info
);
   import rbmd_pkg::*;

   localparam int OcW = $clog2(MAX_OUT_WIDTH + 1);
   localparam int AddrW = $clog2(MAX_OUT_WIDTH);
   localparam logic [OcW-1:0] OcLimit = OcW'(MAX_OUT_WIDTH);
   localparam logic [OcW-1:0] OcLast = OcW'(MAX_OUT_WIDTH - 1);

   logic [DimW-1:0]     pixel_column_ff, pixel_column_in;
   logic [DimW-1:0]     pixel_row_ff, pixel_row_in;
   logic [CellCntW-1:0] column_in_cell_ff, column_in_cell_in;
   logic [CellCntW-1:0] row_in_cell_ff, row_in_cell_in;
   logic [OcW-1:0]      out_column_ff, out_column_in;
   logic [RowW-1:0]     out_row_ff, out_row_in;

   logic row_end, last_pixel_row, image_end, col_end, cell_row_last, cell_row_end;
   logic in_range, lor;

   always_comb begin
      row_end        = ({1'b0, pixel_column_ff} + 17'd1) >= {1'b0, width};
      last_pixel_row = ({1'b0, pixel_row_ff} + 17'd1) >= {1'b0, height};
      image_end      = row_end && last_pixel_row;
      col_end        = row_end || (({1'b0, column_in_cell_ff} + 9'd1) >= factor);
      cell_row_last  = ({1'b0, row_in_cell_ff} + 9'd1) >= factor;
      cell_row_end   = last_pixel_row || cell_row_last;
      in_range       = out_column_ff < OcLimit;
      lor            = row_end || (out_column_ff == OcLast);

      info.first         = (row_in_cell_ff == '0) && (column_in_cell_ff == '0);
      info.emit          = col_end && cell_row_end && in_range;
      info.in_range      = in_range;
      info.last_of_row   = lor;
      info.last_of_image = lor && last_pixel_row;
      info.column        = ColW'(out_column_ff);
      info.row           = out_row_ff;
      addr               = out_column_ff[AddrW-1:0];
   end

   always_comb begin
      pixel_column_in   = pixel_column_ff;
      pixel_row_in      = pixel_row_ff;
      column_in_cell_in = column_in_cell_ff;
      row_in_cell_in    = row_in_cell_ff;
      out_column_in     = out_column_ff;
      out_row_in        = out_row_ff;
      if (step) begin
         if (row_end) begin
            pixel_column_in   = '0;
            column_in_cell_in = '0;
            out_column_in     = '0;
            if (image_end) begin
               pixel_row_in   = '0;
               row_in_cell_in = '0;
               out_row_in     = '0;
            end else if (cell_row_last) begin
               row_in_cell_in = '0;
               out_row_in     = out_row_ff + RowW'(1);
               pixel_row_in   = pixel_row_ff + DimW'(1);
            end else begin
               row_in_cell_in = row_in_cell_ff + CellCntW'(1);
               pixel_row_in   = pixel_row_ff + DimW'(1);
            end
         end else begin
            pixel_column_in = pixel_column_ff + DimW'(1);
            if (({1'b0, column_in_cell_ff} + 9'd1) >= factor) begin
               column_in_cell_in = '0;
               if (in_range) begin
                  out_column_in = out_column_ff + OcW'(1);
               end
            end else begin
               column_in_cell_in = column_in_cell_ff + CellCntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_column_ff   <= '0;
         pixel_row_ff      <= '0;
         column_in_cell_ff <= '0;
         row_in_cell_ff    <= '0;
         out_column_ff     <= '0;
         out_row_ff        <= '0;
      end else begin
         pixel_column_ff   <= pixel_column_in;
         pixel_row_ff      <= pixel_row_in;
         column_in_cell_ff <= column_in_cell_in;
         row_in_cell_ff    <= row_in_cell_in;
         out_column_ff     <= out_column_in;
         out_row_ff        <= out_row_in;
      end
   end

endmodule

// File: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rbmd_pkg::*;

   localparam int SettleCycles = 6;
   localparam int StallLimit   = 2000;
   localparam int RandomQuota  = 650;

   typedef struct packed {
      logic                is_csr;
      csr_index_type       csr;
      logic [CsrDataW-1:0] word;
      logic                not_finite;
      logic                typed;
      rsp_type             want;
   } plan_row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_BLOCK_FACTOR;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // Register copies, as the block holds them after reset.
   logic [FactorW-1:0]        cfg_factor        = BlockFactorReset;
   logic [DimW-1:0]           cfg_width         = InWidthReset;
   logic [DimW-1:0]           cfg_height        = InHeightReset;
   logic                      cfg_nodata_enable = NodataEnableReset;
   logic signed [SampleW-1:0] cfg_nodata_value  = NodataValueReset;

   // Running maximum and has-value bit per output column, plus the scan position.
   logic signed [SampleW-1:0] line_max_copy [0:MaxOutWidth-1];
   logic                      line_has_copy [0:MaxOutWidth-1];
   int unsigned               pix_col      = 0;
   int unsigned               pix_row      = 0;
   int unsigned               col_in_block = 0;
   int unsigned               row_in_block = 0;
   int unsigned               out_col      = 0;
   logic [RowW-1:0]           out_row      = '0;

   rsp_type      expected_cells [$];
   plan_row_type raster_plan [$];

   bit idling         = 1'b1;
   int stall_left     = 0;
   int stalled_cycles = 0;
   int mismatch_count = 0;
   int cells_checked  = 0;
   int samples_sent   = 0;
   int settings_used  = 0;

   raster_block_max_downsample dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_nodata(input logic signed [SampleW-1:0] value);
      if (cfg_nodata_enable)
         return value == cfg_nodata_value;
      return value == Sentinel0 || value == Sentinel1 || value == Sentinel2 ||
             value == Sentinel3;
   endfunction

   // Folds one sample into its pooling block; returns 1 when the block is complete.
   function automatic bit pool_sample(input req_type px, output rsp_type pooled);
      int unsigned factor;
      int unsigned width;
      int unsigned height;
      bit          usable;
      bit          row_end;
      bit          image_end;
      bit          col_end;
      bit          block_row_end;
      bit          emits;
      factor = (cfg_factor == 0) ? 1 : ((cfg_factor > 256) ? 256 : cfg_factor);
      width  = (cfg_width == 0) ? 1 : cfg_width;
      height = (cfg_height == 0) ? 1 : cfg_height;
      usable = !px.not_finite && !is_nodata(px.sample);
      row_end       = pix_col + 1 >= width;
      image_end     = row_end && pix_row + 1 >= height;
      col_end       = row_end || col_in_block + 1 >= factor;
      block_row_end = (pix_row + 1 >= height) || row_in_block + 1 >= factor;
      pooled = '0;
      emits  = 1'b0;
      if (out_col < MaxOutWidth) begin
         if (row_in_block == 0 && col_in_block == 0) begin
            line_has_copy[out_col] = usable;
            line_max_copy[out_col] = usable ? px.sample : '0;
         end else if (usable) begin
            if (!line_has_copy[out_col] ||
                $signed(px.sample) > $signed(line_max_copy[out_col]))
               line_max_copy[out_col] = px.sample;
            line_has_copy[out_col] = 1'b1;
         end
         if (col_end && block_row_end) begin
            emits = 1'b1;
            pooled.cell_has_value = line_has_copy[out_col];
            pooled.cell_value     = line_has_copy[out_col] ? line_max_copy[out_col] : '0;
            pooled.cell_column    = ColW'(out_col);
            pooled.cell_row       = out_row;
            pooled.last_of_row    = row_end || out_col == MaxOutWidth - 1;
            pooled.last_of_image  = pooled.last_of_row && pix_row + 1 >= height;
         end
      end
      if (row_end) begin
         pix_col      = 0;
         col_in_block = 0;
         out_col      = 0;
         if (image_end) begin
            pix_row      = 0;
            row_in_block = 0;
            out_row      = '0;
         end else if (row_in_block + 1 >= factor) begin
            row_in_block = 0;
            out_row      = out_row + 1'b1;
            pix_row++;
         end else begin
            row_in_block++;
            pix_row++;
         end
      end else begin
         pix_col++;
         if (col_in_block + 1 >= factor) begin
            col_in_block = 0;
            if (out_col < MaxOutWidth) out_col++;
         end else begin
            col_in_block++;
         end
      end
      return emits;
   endfunction

   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idling || roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type draw_sample();
      req_type px;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         px.sample = $urandom();
      end else if (roll < 60) begin
         px.sample = $urandom_range(0, 4095) - 2048;
      end else if (roll < 70) begin
         case ($urandom_range(0, 3))
            0:       px.sample = Sentinel0;
            1:       px.sample = Sentinel1;
            2:       px.sample = Sentinel2;
            default: px.sample = Sentinel3;
         endcase
      end else if (roll < 85) begin
         // The declared no-data value and its two neighbors.
         px.sample = cfg_nodata_value + $urandom_range(0, 2) - 1;
      end else begin
         px.sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      px.not_finite = ($urandom_range(0, 9) == 0);
      return px;
   endfunction

   function automatic void plan_register(input csr_index_type idx,
                                         input logic [CsrDataW-1:0] word);
      plan_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.csr    = idx;
      row.word   = word;
      raster_plan.insert(raster_plan.size(), row);
   endfunction

   function automatic void plan_sample(input logic [SampleW-1:0] word, input logic nf);
      plan_row_type row;
      row            = '0;
      row.word       = word;
      row.not_finite = nf;
      raster_plan.insert(raster_plan.size(), row);
   endfunction

   function automatic void plan_checked(input logic [SampleW-1:0] word, input logic nf,
                                        input logic [SampleW-1:0] value, input logic has,
                                        input int col, input int row_index,
                                        input logic lor, input logic loi);
      plan_row_type row;
      row                     = '0;
      row.word                = word;
      row.not_finite          = nf;
      row.typed               = 1'b1;
      row.want.cell_value     = value;
      row.want.cell_has_value = has;
      row.want.cell_column    = ColW'(col);
      row.want.cell_row       = RowW'(row_index);
      row.want.last_of_row    = lor;
      row.want.last_of_image  = loi;
      raster_plan.insert(raster_plan.size(), row);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Holds the sender off until every pending cell has come out and the pipeline is empty.
   task automatic wait_for_cells();
      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataW-1:0] word);
      wait_for_cells();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      @(posedge clock);
      case (idx)
         CSR_BLOCK_FACTOR:  cfg_factor        = word[FactorW-1:0];
         CSR_IN_WIDTH:      cfg_width         = word[DimW-1:0];
         CSR_IN_HEIGHT:     cfg_height        = word[DimW-1:0];
         CSR_NODATA_ENABLE: cfg_nodata_enable = word[0];
         CSR_NODATA_VALUE:  cfg_nodata_value  = word;
         default: ;
      endcase
   endtask

   // Entered at a rising edge; returns at the edge where the transaction is accepted.
   task automatic send_pixel(input req_type px, input bit typed, input rsp_type typed_cell);
      int      pause;
      bit      emits;
      rsp_type pooled;
      pause  = pick_pause();
      csr_we <= 1'b0;
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      emits = pool_sample(px, pooled);
      if (typed) expected_cells.insert(expected_cells.size(), typed_cell);
      else if (emits) expected_cells.insert(expected_cells.size(), pooled);
      samples_sent++;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (idling && $urandom_range(0, 3) == 0) stall_left = pick_pause();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected cell at column %0d row %0d",
                                      rsp_data.cell_column, rsp_data.cell_row));
         end else begin
            want = expected_cells.pop_front();
            cells_checked++;
            if (rsp_data.cell_value !== want.cell_value)
               report_mismatch($sformatf("cell (%0d,%0d) cell_value %0d, expected %0d",
                  want.cell_column, want.cell_row, rsp_data.cell_value, want.cell_value));
            if (rsp_data.cell_has_value !== want.cell_has_value)
               report_mismatch($sformatf("cell (%0d,%0d) cell_has_value %b, expected %b",
                  want.cell_column, want.cell_row, rsp_data.cell_has_value,
                  want.cell_has_value));
            if (rsp_data.cell_column !== want.cell_column)
               report_mismatch($sformatf("cell (%0d,%0d) cell_column %0d",
                  want.cell_column, want.cell_row, rsp_data.cell_column));
            if (rsp_data.cell_row !== want.cell_row)
               report_mismatch($sformatf("cell (%0d,%0d) cell_row %0d",
                  want.cell_column, want.cell_row, rsp_data.cell_row));
            if (rsp_data.last_of_row !== want.last_of_row)
               report_mismatch($sformatf("cell (%0d,%0d) last_of_row %b, expected %b",
                  want.cell_column, want.cell_row, rsp_data.last_of_row, want.last_of_row));
            if (rsp_data.last_of_image !== want.last_of_image)
               report_mismatch($sformatf("cell (%0d,%0d) last_of_image %b, expected %b",
                  want.cell_column, want.cell_row, rsp_data.last_of_image,
                  want.last_of_image));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else if (stalled_cycles == StallLimit) begin
         $display("Timeout: no transaction in %0d cycles, %0d cells still pending",
                  StallLimit, expected_cells.size());
         $display("status: fail");
         $finish;
      end else begin
         stalled_cycles++;
      end
   end

   initial begin : stimulus
      req_type             px;
      int                  roll;
      int                  random_samples;
      int                  pixels;
      logic [FactorW-1:0]  factor;
      logic [DimW-1:0]     width;
      logic [DimW-1:0]     height;
      logic [CsrDataW-1:0] nodata;

      // Reset registers: every sample is its own cell along a 4096-wide row.
      plan_checked(32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b1, 0, 0, 1'b0, 1'b0);
      plan_checked(32'h8000_0000, 1'b0, 32'h8000_0000, 1'b1, 1, 0, 1'b0, 1'b0);
      plan_checked(Sentinel0, 1'b0, 32'd0, 1'b0, 2, 0, 1'b0, 1'b0);
      plan_checked(Sentinel1, 1'b0, 32'd0, 1'b0, 3, 0, 1'b0, 1'b0);
      plan_checked(Sentinel2, 1'b0, 32'd0, 1'b0, 4, 0, 1'b0, 1'b0);
      plan_checked(Sentinel3, 1'b0, 32'd0, 1'b0, 5, 0, 1'b0, 1'b0);
      plan_checked(32'd100, 1'b1, 32'd0, 1'b0, 6, 0, 1'b0, 1'b0);
      plan_checked(32'd0, 1'b0, 32'd0, 1'b1, 7, 0, 1'b0, 1'b0);
      // Shrinking the row mid-way ends it at the next sample; shrinking the image makes this row its last.
      plan_register(CSR_IN_WIDTH, 32'd2);
      plan_checked(32'd5, 1'b0, 32'd5, 1'b1, 8, 0, 1'b1, 1'b0);
      plan_register(CSR_IN_HEIGHT, 32'd0);
      plan_checked(-32'sd1, 1'b0, -32'sd1, 1'b1, 0, 1, 1'b0, 1'b0);
      plan_checked(-32'sd2, 1'b0, -32'sd2, 1'b1, 1, 1, 1'b1, 1'b1);
      // Declared no-data value at the negative extreme; a zero factor acts as one.
      plan_register(CSR_NODATA_ENABLE, 32'd1);
      plan_register(CSR_NODATA_VALUE, 32'h8000_0000);
      plan_register(CSR_BLOCK_FACTOR, 32'd0);
      plan_register(CSR_IN_WIDTH, 32'd3);
      plan_register(CSR_IN_HEIGHT, 32'd1);
      plan_checked(32'h8000_0000, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0, 1'b0);
      plan_checked(32'd0, 1'b0, 32'd0, 1'b1, 1, 0, 1'b0, 1'b0);
      plan_checked(Sentinel0, 1'b0, Sentinel0, 1'b1, 2, 0, 1'b1, 1'b1);
      // An oversized factor clamps to 256, so the whole 3x2 image is one cell.
      plan_register(CSR_NODATA_VALUE, 32'h7FFF_FFFF);
      plan_register(CSR_BLOCK_FACTOR, 32'd511);
      plan_register(CSR_IN_HEIGHT, 32'd2);
      plan_sample(32'h7FFF_FFFF, 1'b0);
      plan_sample(-32'sd5, 1'b1);
      plan_sample(-32'sd10, 1'b0);
      plan_sample(-32'sd20, 1'b0);
      plan_sample(32'h7FFF_FFFF, 1'b0);
      plan_checked(-32'sd3, 1'b0, -32'sd3, 1'b1, 0, 0, 1'b1, 1'b1);
      // A cell made only of sentinels and non-finite samples has no value.
      plan_register(CSR_NODATA_ENABLE, 32'd0);
      plan_register(CSR_BLOCK_FACTOR, 32'd2);
      plan_register(CSR_IN_WIDTH, 32'd2);
      plan_sample(Sentinel3, 1'b0);
      plan_sample(32'd1, 1'b1);
      plan_sample(Sentinel2, 1'b0);
      plan_checked(Sentinel1, 1'b0, 32'd0, 1'b0, 0, 0, 1'b1, 1'b1);
      // A zero width acts as one column.
      plan_register(CSR_IN_WIDTH, 32'd0);
      plan_sample(32'h7FFF_FFFE, 1'b0);
      plan_sample(32'd16, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (raster_plan[k]) begin
         if (raster_plan[k].is_csr) begin
            write_csr(raster_plan[k].csr, raster_plan[k].word);
         end else begin
            px.sample     = raster_plan[k].word;
            px.not_finite = raster_plan[k].not_finite;
            send_pixel(px, raster_plan[k].typed, raster_plan[k].want);
         end
      end

      // Random settings, each run over whole images so no cell straddles a change.
      random_samples = 0;
      while (random_samples < RandomQuota) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) factor = '0;
         else if (roll == 1) factor = FactorMax;
         else if (roll == 2) factor = FactorW'($urandom_range(257, 511));
         else factor = FactorW'($urandom_range(1, 5));
         roll = $urandom_range(0, 19);
         if (roll == 0) width = '0;
         else if (roll == 1) width = DimW'($urandom_range(25, 70));
         else width = DimW'($urandom_range(1, 24));
         height = ($urandom_range(0, 19) == 0) ? '0 : DimW'($urandom_range(1, 10));
         case ($urandom_range(0, 4))
            0:       nodata = $urandom();
            1:       nodata = Sentinel2;
            2:       nodata = '0;
            3:       nodata = 32'h7FFF_FFFF;
            default: nodata = 32'h8000_0000;
         endcase
         write_csr(CSR_BLOCK_FACTOR, CsrDataW'(factor));
         write_csr(CSR_IN_WIDTH, CsrDataW'(width));
         write_csr(CSR_IN_HEIGHT, CsrDataW'(height));
         write_csr(CSR_NODATA_ENABLE, CsrDataW'($urandom_range(0, 1)));
         write_csr(CSR_NODATA_VALUE, nodata);
         settings_used++;
         idling = ($urandom_range(0, 3) != 0);
         pixels = ((width == 0) ? 1 : width) * ((height == 0) ? 1 : height);
         repeat ($urandom_range(1, 3)) begin
            for (int n = 0; n < pixels; n++) begin
               if ($urandom_range(0, 99) == 0) wait_for_cells();
               send_pixel(draw_sample(), 1'b0, '0);
               random_samples++;
            end
         end
      end

      // Largest factor along a row: one full 256-wide cell and a partial one.
      idling = 1'b0;
      write_csr(CSR_BLOCK_FACTOR, 32'd256);
      write_csr(CSR_IN_WIDTH, 32'd300);
      write_csr(CSR_IN_HEIGHT, 32'd1);
      settings_used++;
      repeat (300) send_pixel(draw_sample(), 1'b0, '0);

      // Largest factor down a single column.
      idling = 1'b1;
      write_csr(CSR_IN_WIDTH, 32'd1);
      write_csr(CSR_IN_HEIGHT, 32'd300);
      settings_used++;
      repeat (300) send_pixel(draw_sample(), 1'b0, '0);

      wait_for_cells();

      $display("Sent %0d samples under %0d register settings and compared %0d cells.",
               samples_sent, settings_used, cells_checked);
      $display("Factors 0 to 511, partial edge cells, 256-pixel cells, sentinel and declared no-data.");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
